FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the collision-time block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/sct_pkg.sv
// Package of constants for the swept circle collision-time pipeline.
`default_nettype none
package sct_pkg;
   localparam int unsigned SQRT_STEPS = 30;   // root bits of a 60-bit discriminant
   localparam int unsigned DIV_STEPS  = 32;   // quotient bits before saturation
   localparam int unsigned FRAC_BITS  = 16;
   // front stages, sqrt steps, numerator stage, divide steps, output register
   localparam int unsigned LATENCY    = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
endpackage
`default_nettype wire

FILE: hw/rtl/swept_circle_collision_time.sv
// Top level of the swept circle collision-time pipeline.
// The block takes one transaction per clock cycle: busy is always low, so every cycle
// with start high is accepted. Each result appears on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, in order. The path holds the front stages, the
// 30 one-bit steps of the pipelined square root, a numerator stage, the 32 one-bit
// steps of the pipelined divider and the output register. Since nothing can hold
// results off, results must be taken in the cycle they appear.
`default_nettype none
`include "assert_macros.svh"
module swept_circle_collision_time
   import sct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_first_pos_x,
   input  wire logic [15:0] req_first_pos_y,
   input  wire logic [12:0] req_first_vel_x,
   input  wire logic [12:0] req_first_vel_y,
   input  wire logic [10:0] req_first_radius,
   input  wire logic [15:0] req_second_pos_x,
   input  wire logic [15:0] req_second_pos_y,
   input  wire logic [12:0] req_second_vel_x,
   input  wire logic [12:0] req_second_vel_y,
   input  wire logic [10:0] req_second_radius,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [31:0]      rsp_contact_time
);

   // Stage 1: relative position, velocity and summed radius.
   logic               v1_ff;
   logic signed [16:0] dpx1_ff, dpy1_ff;
   logic signed [13:0] dvx1_ff, dvy1_ff;
   logic [11:0]        r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      dpx1_ff <= {req_second_pos_x[15], req_second_pos_x} - {req_first_pos_x[15], req_first_pos_x};
      dpy1_ff <= {req_second_pos_y[15], req_second_pos_y} - {req_first_pos_y[15], req_first_pos_y};
      dvx1_ff <= {req_second_vel_x[12], req_second_vel_x} - {req_first_vel_x[12], req_first_vel_x};
      dvy1_ff <= {req_second_vel_y[12], req_second_vel_y} - {req_first_vel_y[12], req_first_vel_y};
      r1_ff   <= {1'b0, req_first_radius} + {1'b0, req_second_radius};
   end

   // Stage 2: the individual products.
   logic signed [27:0] axx_w, ayy_w;
   logic signed [30:0] hx_w, hy_w;
   logic signed [33:0] cxx_w, cyy_w;
   logic               v2_ff;
   logic [26:0]        ax2_ff, ay2_ff;
   logic signed [30:0] hx2_ff, hy2_ff;
   logic [31:0]        cx2_ff, cy2_ff;
   logic [23:0]        rr2_ff;

   assign axx_w = dvx1_ff * dvx1_ff;
   assign ayy_w = dvy1_ff * dvy1_ff;
   assign hx_w  = dvx1_ff * dpx1_ff;
   assign hy_w  = dvy1_ff * dpy1_ff;
   assign cxx_w = dpx1_ff * dpx1_ff;
   assign cyy_w = dpy1_ff * dpy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      ax2_ff <= axx_w[26:0];
      ay2_ff <= ayy_w[26:0];
      hx2_ff <= hx_w;
      hy2_ff <= hy_w;
      cx2_ff <= cxx_w[31:0];
      cy2_ff <= cyy_w[31:0];
      rr2_ff <= r1_ff * r1_ff;
   end

   // Stage 3: quadratic coefficients a, h and c.
   logic               v3_ff;
   logic [27:0]        a3_ff;
   logic signed [30:0] h3_ff;
   logic signed [34:0] c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      a3_ff <= {1'b0, ax2_ff} + {1'b0, ay2_ff};
      h3_ff <= hx2_ff + hy2_ff;
      c3_ff <= {3'b0, cx2_ff} + {3'b0, cy2_ff} - {11'b0, rr2_ff};
   end

   // Stage 4: h squared and a*c in two halves. Only c >= 0 ever reaches the root.
   logic [33:0]        cu_w;
   logic signed [61:0] hh_w;
   logic               v4_ff, azero4_ff, hpos4_ff, cneg4_ff;
   logic [59:0]        hh4_ff;
   logic [44:0]        aclo4_ff, achi4_ff;
   logic [27:0]        a4_ff;
   logic [30:0]        nh4_ff;

   assign cu_w = c3_ff[34] ? 34'd0 : c3_ff[33:0];
   assign hh_w = h3_ff * h3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      hh4_ff    <= hh_w[59:0];
      aclo4_ff  <= a3_ff * cu_w[16:0];
      achi4_ff  <= a3_ff * cu_w[33:17];
      azero4_ff <= (a3_ff == 28'd0);
      hpos4_ff  <= !h3_ff[30] && (h3_ff != 31'sd0);
      cneg4_ff  <= c3_ff[34];
      a4_ff     <= a3_ff;
      nh4_ff    <= 31'd0 - h3_ff;
   end

   // Stage 5: discriminant and case decision; feeds square root step 0.
   logic [61:0] ac_w, d_w;
   logic        calc_w, direct_w;

   logic        sq_valid_ff  [0:SQRT_STEPS];
   logic        sq_calc_ff   [0:SQRT_STEPS];
   logic        sq_direct_ff [0:SQRT_STEPS];
   logic [27:0] sq_a_ff      [0:SQRT_STEPS];
   logic [30:0] sq_nh_ff     [0:SQRT_STEPS];
   logic [33:0] sq_rem_ff    [0:SQRT_STEPS];
   logic [29:0] sq_root_ff   [0:SQRT_STEPS];
   logic [59:0] sq_d_ff      [0:SQRT_STEPS];

   assign ac_w     = {achi4_ff, 17'd0} + {17'd0, aclo4_ff};
   assign d_w      = {2'b00, hh4_ff} - ac_w;
   assign calc_w   = !azero4_ff && !hpos4_ff && !cneg4_ff && !d_w[61];
   assign direct_w = azero4_ff && cneg4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= v4_ff;
      end
      sq_calc_ff[0]   <= calc_w;
      sq_direct_ff[0] <= direct_w;
      sq_a_ff[0]      <= a4_ff;
      sq_nh_ff[0]     <= nh4_ff;
      sq_rem_ff[0]    <= 34'd0;
      sq_root_ff[0]   <= 30'd0;
      sq_d_ff[0]      <= d_w[59:0];
   end

   // Square root, two discriminant bits and one root bit per stage.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [33:0] shifted_w, trial_w;
      logic        ge_w;

      assign shifted_w = {sq_rem_ff[k][31:0], sq_d_ff[k][59:58]};
      assign trial_w   = {2'b00, sq_root_ff[k], 2'b01};
      assign ge_w      = (shifted_w >= trial_w);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         sq_calc_ff[k+1]   <= sq_calc_ff[k];
         sq_direct_ff[k+1] <= sq_direct_ff[k];
         sq_a_ff[k+1]      <= sq_a_ff[k];
         sq_nh_ff[k+1]     <= sq_nh_ff[k];
         sq_rem_ff[k+1]    <= ge_w ? (shifted_w - trial_w) : shifted_w;
         sq_root_ff[k+1]   <= {sq_root_ff[k][28:0], ge_w};
         sq_d_ff[k+1]      <= {sq_d_ff[k][57:0], 2'b00};
      end
   end

   // Numerator and saturation check; feeds divide step 0.
   logic [30:0] num_w;
   logic        sat_w;

   logic        dv_valid_ff  [0:DIV_STEPS];
   logic        dv_calc_ff   [0:DIV_STEPS];
   logic        dv_direct_ff [0:DIV_STEPS];
   logic        dv_sat_ff    [0:DIV_STEPS];
   logic [27:0] dv_a_ff      [0:DIV_STEPS];
   logic [27:0] dv_rem_ff    [0:DIV_STEPS];
   logic [31:0] dv_q_ff      [0:DIV_STEPS];
   logic [31:0] dv_n_ff      [0:DIV_STEPS];

   assign num_w = sq_nh_ff[SQRT_STEPS] - {1'b0, sq_root_ff[SQRT_STEPS]};
   // The quotient reaches 2^32 exactly when the numerator's top bits reach a.
   assign sat_w = ({13'd0, num_w[30:FRAC_BITS]} >= sq_a_ff[SQRT_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= sq_valid_ff[SQRT_STEPS];
      end
      dv_calc_ff[0]   <= sq_calc_ff[SQRT_STEPS];
      dv_direct_ff[0] <= sq_direct_ff[SQRT_STEPS];
      dv_sat_ff[0]    <= sat_w;
      dv_a_ff[0]      <= sq_a_ff[SQRT_STEPS];
      dv_rem_ff[0]    <= {13'd0, num_w[30:FRAC_BITS]};
      dv_q_ff[0]      <= 32'd0;
      dv_n_ff[0]      <= {num_w[FRAC_BITS-1:0], 16'd0};
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [28:0] partial_w, diff_w;
      logic        ge_w;

      assign partial_w = {dv_rem_ff[j], dv_n_ff[j][31]};
      assign ge_w      = (partial_w >= {1'b0, dv_a_ff[j]});
      assign diff_w    = partial_w - {1'b0, dv_a_ff[j]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         dv_calc_ff[j+1]   <= dv_calc_ff[j];
         dv_direct_ff[j+1] <= dv_direct_ff[j];
         dv_sat_ff[j+1]    <= dv_sat_ff[j];
         dv_a_ff[j+1]      <= dv_a_ff[j];
         dv_rem_ff[j+1]    <= ge_w ? diff_w[27:0] : partial_w[27:0];
         dv_q_ff[j+1]      <= {dv_q_ff[j][30:0], ge_w};
         dv_n_ff[j+1]      <= {dv_n_ff[j][30:0], 1'b0};
      end
   end

   // Output register.
   logic        out_valid_ff, out_hit_ff;
   logic [31:0] out_time_ff;
   logic        out_hit_in;
   logic [31:0] out_time_in;

   always_comb begin
      out_hit_in  = dv_valid_ff[DIV_STEPS]
                    && (dv_calc_ff[DIV_STEPS] || dv_direct_ff[DIV_STEPS]);
      out_time_in = 32'd0;
      if (dv_valid_ff[DIV_STEPS] && dv_calc_ff[DIV_STEPS]) begin
         out_time_in = dv_sat_ff[DIV_STEPS] ? 32'hFFFF_FFFF : dv_q_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_hit_ff   <= 1'b0;
         out_time_ff  <= 32'd0;
      end else begin
         out_valid_ff <= dv_valid_ff[DIV_STEPS];
         out_hit_ff   <= out_hit_in;
         out_time_ff  <= out_time_in;
      end
   end

   assign busy             = 1'b0;
   assign rsp_valid        = out_valid_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_contact_time = out_time_ff;

   `ASSERT_AT(a_result_follows_transaction, clock, reset, rsp_valid |-> $past(start, LATENCY))
   `ASSERT_NEVER(a_hit_only_with_valid, clock, reset, rsp_hit && !rsp_valid)
   `ASSERT_NEVER(a_time_only_with_hit, clock, reset, (rsp_contact_time != 32'd0) && !rsp_hit)
   `ASSERT_NEVER(a_one_case_only, clock, reset, v4_ff && calc_w && direct_w)

endmodule
`default_nettype wire

FILE: tb/swept_circle_collision_time_tb.sv
// Self-checking testbench for the swept circle collision-time pipeline.
`timescale 1ns / 1ps
`default_nettype none
module swept_circle_collision_time_tb
   import sct_pkg::*;
;

   typedef struct packed {
      logic        hit;
      logic [31:0] contact_time;
   } impact_type;

   class impact_scoreboard;
      impact_type pending[$];
      int         errors = 0;

      // Floor square root by the bitwise method, on 64 bits.
      function longint unsigned floor_sqrt(longint unsigned n);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > n) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      function void note_pair(logic signed [15:0] p1x, p1y, logic signed [12:0] v1x, v1y,
                              logic [10:0] r1, logic signed [15:0] p2x, p2y,
                              logic signed [12:0] v2x, v2y, logic [10:0] r2);
         longint dpx, dpy, dvx, dvy, rr, qa, qh, qc, disc;
         longint unsigned num, quo;
         impact_type e;
         dpx = longint'(p2x) - longint'(p1x);
         dpy = longint'(p2y) - longint'(p1y);
         dvx = longint'(v2x) - longint'(v1x);
         dvy = longint'(v2y) - longint'(v1y);
         rr = longint'(r1) + longint'(r2);
         qa = dvx * dvx + dvy * dvy;
         qh = dvx * dpx + dvy * dpy;
         qc = dpx * dpx + dpy * dpy - rr * rr;
         disc = qh * qh - qa * qc;
         e = '0;
         if (disc < 0) begin
            e.hit = 1'b0;
         end else if (qa == 0) begin
            e.hit = (qc < 0);
         end else if (qh <= 0 && qc >= 0) begin
            num = longint'(-qh) - floor_sqrt(disc);
            quo = (num << FRAC_BITS) / longint'(qa);
            e.hit = 1'b1;
            e.contact_time = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
         end
         pending = {pending, e};
      endfunction

      function void check_result(logic hit, logic [31:0] ctime);
         impact_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result hit=%0b time=%h", $time, hit, ctime);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
            errors++;
         end
         if (ctime !== e.contact_time) begin
            $display("%0t: contact_time expected %h actual %h", $time, e.contact_time, ctime);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid, rsp_hit;
   logic [15:0] p1x, p1y, p2x, p2y;
   logic [12:0] v1x, v1y, v2x, v2y;
   logic [10:0] r1, r2;
   logic [31:0] rsp_contact_time;
   impact_scoreboard sb;

   swept_circle_collision_time DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_pos_x(p1x), .req_first_pos_y(p1y),
      .req_first_vel_x(v1x), .req_first_vel_y(v1y), .req_first_radius(r1),
      .req_second_pos_x(p2x), .req_second_pos_y(p2y),
      .req_second_vel_x(v2x), .req_second_vel_y(v2y), .req_second_radius(r2),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_contact_time(rsp_contact_time)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("swept_circle_collision_time regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_hit, rsp_contact_time);
   end

   // Presents one transaction, holding start until it is taken, after a random gap unless no_gap is set.
   task automatic send_pair(logic [15:0] a1x, a1y, logic [12:0] b1x, b1y, logic [10:0] c1,
                            logic [15:0] a2x, a2y, logic [12:0] b2x, b2y, logic [10:0] c2,
                            bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : int'($urandom_range(0, 9));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      p1x <= a1x; p1y <= a1y; v1x <= b1x; v1y <= b1y; r1 <= c1;
      p2x <= a2x; p2y <= a2y; v2x <= b2x; v2y <= b2y; r2 <= c2;
      do @(posedge clock); while (busy);
      sb.note_pair(a1x, a1y, b1x, b1y, c1, a2x, a2y, b2x, b2y, c2);
   endtask

   task automatic send_random(bit near, bit no_gap);
      logic [15:0] a1x, a1y, a2x, a2y;
      logic [12:0] b1x, b1y, b2x, b2y;
      logic [10:0] c1, c2;
      a1x = 16'($urandom); a1y = 16'($urandom);
      b1x = 13'($urandom); b1y = 13'($urandom);
      b2x = 13'($urandom); b2y = 13'($urandom);
      c1 = 11'($urandom); c2 = 11'($urandom);
      if (near) begin
         // Second circle placed close by and heading back, so contact is likely.
         a2x = a1x + 16'($urandom_range(0, 8000)) - 16'd4000;
         a2y = a1y + 16'($urandom_range(0, 8000)) - 16'd4000;
         b2x = b1x - 13'($signed(a2x - a1x) >>> $urandom_range(0, 4));
         b2y = b1y - 13'($signed(a2y - a1y) >>> $urandom_range(0, 4));
         if ($urandom_range(0, 9) == 0) begin
            b2x = b1x;
            b2y = b1y;
         end
         if ($urandom_range(0, 3) == 0) begin
            c1 = 11'($urandom_range(0, 15));
            c2 = 11'($urandom_range(0, 15));
         end
      end else begin
         a2x = 16'($urandom); a2y = 16'($urandom);
      end
      send_pair(a1x, a1y, b1x, b1y, c1, a2x, a2y, b2x, b2y, c2, no_gap);
   endtask

   initial begin
      bit burst;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      {p1x, p1y, p2x, p2y} = '0;
      {v1x, v1y, v2x, v2y} = '0;
      {r1, r2} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: overlap at rest, touching at rest, apart at rest.
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd10,
                16'd5, 16'd0, 13'd0, 13'd0, 11'd10);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd10,
                16'd20, 16'd0, 13'd0, 13'd0, 11'd10);
      send_pair(16'd0, 16'd0, 13'd5, 13'd5, 11'd1,
                16'd100, 16'd100, 13'd5, 13'd5, 11'd1);
      // Approaching head-on, receding, overlapping while moving, near miss.
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd5,
                16'd100, 16'd0, -13'sd10, 13'd0, 11'd5);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd5,
                16'd100, 16'd0, 13'sd10, 13'd0, 11'd5);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd50,
                16'd10, 16'd0, -13'sd1, 13'd0, 11'd50);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd1,
                16'd100, 16'd50, -13'sd10, 13'd0, 11'd1);
      // Grazing contact and exact touch with approach.
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd5,
                16'd100, 16'd10, -13'sd10, 13'd0, 11'd5);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd5,
                16'd10, 16'd0, -13'sd3, 13'd0, 11'd5);
      // Extremes: saturating time, widest distances and speeds, largest radii.
      send_pair(16'h8000, 16'h8000, 13'd0, 13'd0, 11'd0,
                16'h7FFF, 16'h7FFF, -13'sd1, -13'sd1, 11'd0);
      send_pair(16'h8000, 16'h8000, 13'h0FFF, 13'h0FFF, 11'd2047,
                16'h7FFF, 16'h7FFF, 13'h1000, 13'h1000, 11'd2047);
      send_pair(16'h7FFF, 16'h8000, 13'h1000, 13'h0FFF, 11'd2047,
                16'h8000, 16'h7FFF, 13'h0FFF, 13'h1000, 11'd2047);
      send_pair(16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, 11'h7FF,
                16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, 11'h7FF);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd0,
                16'd0, 16'd0, 13'd0, 13'd0, 11'd0);
      send_pair(16'd0, 16'd0, 13'd0, 13'd0, 11'd0,
                16'd3000, 16'd0, 13'h1000, 13'd0, 11'd0);

      for (int i = 0; i < 1250; i++) begin
         if (i == 600) begin
            start <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         burst = (i % 200) < 30;
         send_random($urandom_range(0, 3) != 0, burst);
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("swept_circle_collision_time regression: pass");
      end else begin
         $display("swept_circle_collision_time regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: swept_circle_collision_time.f
+incdir+hw/rtl
hw/rtl/sct_pkg.sv
hw/rtl/swept_circle_collision_time.sv
tb/swept_circle_collision_time_tb.sv
